// File: rtl/core/rcpwd_pkg.sv
// ----------------------------------------------------------------------------
// RC pulse width decoder package
// Shared widths, reset values, codes and types of the pulse width decoder.
// ----------------------------------------------------------------------------
package rcpwd_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int STAMP_BITS_DEF   = 16;
	localparam int NUM_REPORT       = 4;
	localparam int CHAN_W           = 2;
	localparam int CFG_W            = 16;
	localparam int CMD_W            = 16;
	localparam int MISS_W           = 16;
	localparam int REG_IDX_W        = 2;

	localparam logic [CFG_W-1:0] ABORT_HIGH_RST = 16'd2200;
	localparam logic [CFG_W-1:0] CLAMP_HIGH_RST = 16'd2000;
	localparam logic [CFG_W-1:0] ABORT_LOW_RST  = 16'd800;
	localparam logic [CFG_W-1:0] CLAMP_LOW_RST  = 16'd1000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ABORT_HIGH = 2'd0,
		REG_CLAMP_HIGH = 2'd1,
		REG_ABORT_LOW  = 2'd2,
		REG_CLAMP_LOW  = 2'd3
	} reg_idx_t;

	typedef enum logic {
		FUNC_CAPTURE = 1'b0,
		FUNC_TICK    = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_LONG  = 2'd1,
		ERR_SHORT = 2'd2
	} err_code_t;

	typedef struct packed {
		logic [CFG_W-1:0] abort_high;
		logic [CFG_W-1:0] clamp_high;
		logic [CFG_W-1:0] abort_low;
		logic [CFG_W-1:0] clamp_low;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             present;
		err_code_t        err;
	} chan_res_t;

endpackage

// File: rtl/core/rcpwd_cfg.sv
// ----------------------------------------------------------------------------
// RC pulse width decoder configuration registers
// Holds the abort and clamp window limits, written through the config port.
// ----------------------------------------------------------------------------
module rcpwd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [rcpwd_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [rcpwd_pkg::CFG_W-1:0]     wr_data,
	output rcpwd_pkg::cfg_t                 cfg
);
	import rcpwd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.abort_high <= ABORT_HIGH_RST;
			cfg_q.clamp_high <= CLAMP_HIGH_RST;
			cfg_q.abort_low  <= ABORT_LOW_RST;
			cfg_q.clamp_low  <= CLAMP_LOW_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_ABORT_HIGH: cfg_q.abort_high <= wr_data;
				REG_CLAMP_HIGH: cfg_q.clamp_high <= wr_data;
				REG_ABORT_LOW:  cfg_q.abort_low  <= wr_data;
				REG_CLAMP_LOW:  cfg_q.clamp_low  <= wr_data;
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/rcpwd_chan.sv
// ----------------------------------------------------------------------------
// RC pulse width decoder channel
// Edge pairing, width capture, window check, clamp and no-data counter of
// one receiver channel.
// ----------------------------------------------------------------------------
module rcpwd_chan #(
	parameter int STAMP_BITS = rcpwd_pkg::STAMP_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cap_en,
	input  logic                  tick_en,
	input  logic [STAMP_BITS-1:0] stamp,
	input  rcpwd_pkg::cfg_t       cfg,
	output rcpwd_pkg::chan_res_t  res
);
	import rcpwd_pkg::*;

	localparam int W = (STAMP_BITS > CFG_W) ? STAMP_BITS : CFG_W;

	logic                  await_fall_q;
	logic                  fresh_q;
	logic [STAMP_BITS-1:0] rise_q;
	logic [W-1:0]          width_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [MISS_W-1:0]     miss_q;

	logic [STAMP_BITS-1:0] span;
	logic [W-1:0]      ah, chh, al, cl;
	logic [W-1:0]      w1, w2, s1, s2;
	logic              too_long, too_short;
	logic [CMD_W-1:0]  cmd_calc;
	logic [MISS_W-1:0] miss_nxt;

	assign span = stamp - rise_q;

	always_comb begin
		ah  = W'(cfg.abort_high);
		chh = W'(cfg.clamp_high);
		al  = W'(cfg.abort_low);
		cl  = W'(cfg.clamp_low);

		too_long = width_q > ah;
		w1 = width_q;
		if (!too_long && width_q > chh) begin
			w1 = chh;
		end
		too_short = w1 < al;
		w2 = w1;
		if (!too_short && w1 < cl) begin
			w2 = cl;
		end

		s1 = (w2 > chh) ? chh : w2;
		s2 = (s1 < cl) ? cl : s1;
		cmd_calc = CMD_W'(s2 - cl);

		miss_nxt = miss_q;
		if (fresh_q) begin
			miss_nxt = '0;
		end else if (miss_q != {MISS_W{1'b1}}) begin
			miss_nxt = miss_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_fall_q <= 1'b0;
			fresh_q      <= 1'b0;
			rise_q       <= '0;
			width_q      <= '0;
			cmd_q        <= '0;
			miss_q       <= '0;
		end else if (cap_en) begin
			if (!await_fall_q) begin
				rise_q       <= stamp;
				await_fall_q <= 1'b1;
				fresh_q      <= 1'b0;
			end else begin
				width_q      <= W'(span);
				await_fall_q <= 1'b0;
				fresh_q      <= 1'b1;
			end
		end else if (tick_en) begin
			miss_q <= miss_nxt;
			if (fresh_q) begin
				width_q <= w2;
				cmd_q   <= cmd_calc;
			end
		end
	end

	always_comb begin
		res.cmd     = fresh_q ? cmd_calc : cmd_q;
		res.present = (miss_nxt == '0);
		if (fresh_q && too_short) begin
			res.err = ERR_SHORT;
		end else if (fresh_q && too_long) begin
			res.err = ERR_LONG;
		end else begin
			res.err = ERR_NONE;
		end
	end

endmodule

// File: rtl/core/rc_pulse_width_decoder.sv
// ----------------------------------------------------------------------------
// RC pulse width decoder
// Four-channel receiver pulse decoder: pairs capture edges into pulse widths
// and turns them into clamped commands, presence flags and a sticky error.
//
//   port group     direction  handshake            payload
//   in             in         in_valid/in_stall    func, chan, capture_time
//   out            out        out_valid/out_stall  cmd_*, present_mask, error_code
//   cfg            in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while no tick waits. An item is held in the input register,
// where the channel logic acts on it; a tick result lands in the output
// register in the next cycle. Captures give no result and never wait. A tick
// waits in the input register only while a previous result is held by out_stall.
// Reset clears all channel state and loads the default window limits.
// ----------------------------------------------------------------------------
module rc_pulse_width_decoder #(
	parameter int NUM_CHANNELS = rcpwd_pkg::NUM_CHANNELS_DEF,
	parameter int STAMP_BITS   = rcpwd_pkg::STAMP_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [rcpwd_pkg::CHAN_W-1:0]    chan,
	input  logic [STAMP_BITS-1:0]           capture_time,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rcpwd_pkg::CMD_W-1:0]     cmd_throttle,
	output logic [rcpwd_pkg::CMD_W-1:0]     cmd_roll,
	output logic [rcpwd_pkg::CMD_W-1:0]     cmd_pitch,
	output logic [rcpwd_pkg::CMD_W-1:0]     cmd_rudder,
	output logic [rcpwd_pkg::NUM_REPORT-1:0] present_mask,
	output logic [1:0]                      error_code,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rcpwd_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [rcpwd_pkg::CFG_W-1:0]     cfg_data
);
	import rcpwd_pkg::*;

	logic                  valid_s1;
	func_t                 func_s1;
	logic [CHAN_W-1:0]     chan_s1;
	logic [STAMP_BITS-1:0] stamp_s1;

	logic      out_valid_q;
	logic [CMD_W-1:0] cmd_q [NUM_REPORT];
	logic [NUM_REPORT-1:0] present_q;
	err_code_t err_q;
	err_code_t sticky_q;

	cfg_t      cfg;
	chan_res_t res [NUM_CHANNELS];
	logic      fire;
	logic      tick_fire;
	err_code_t err_nxt;
	logic [CMD_W-1:0]      rpt_cmd [NUM_REPORT];
	logic [NUM_REPORT-1:0] rpt_present;

	assign cfg_ready = 1'b1;

	rcpwd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign fire      = valid_s1 && !(func_s1 == FUNC_TICK && out_valid_q && out_stall);
	assign tick_fire = fire && (func_s1 == FUNC_TICK);
	assign in_stall  = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1  <= func_t'(func);
			chan_s1  <= chan;
			stamp_s1 <= capture_time;
		end
	end

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
		rcpwd_chan #(
			.STAMP_BITS (STAMP_BITS)
		) u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.cap_en  (fire && func_s1 == FUNC_CAPTURE && int'(chan_s1) == i),
			.tick_en (tick_fire),
			.stamp   (stamp_s1),
			.cfg     (cfg),
			.res     (res[i])
		);
	end

	for (genvar i = 0; i < NUM_REPORT; i++) begin : g_rpt
		if (i < NUM_CHANNELS) begin : g_on
			assign rpt_cmd[i]     = res[i].cmd;
			assign rpt_present[i] = res[i].present;
		end else begin : g_off
			assign rpt_cmd[i]     = '0;
			assign rpt_present[i] = 1'b0;
		end
	end

	always_comb begin
		err_nxt = sticky_q;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (res[i].err != ERR_NONE) begin
				err_nxt = res[i].err;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sticky_q    <= ERR_NONE;
		end else if (tick_fire) begin
			out_valid_q <= 1'b1;
			sticky_q    <= err_nxt;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			cmd_q     <= rpt_cmd;
			present_q <= rpt_present;
			err_q     <= err_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign cmd_throttle = cmd_q[0];
	assign cmd_roll     = cmd_q[1];
	assign cmd_pitch    = cmd_q[2];
	assign cmd_rudder   = cmd_q[3];
	assign present_mask = present_q;
	assign error_code   = err_q;

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// RC pulse width decoder testbench
// Drives capture edges and loop ticks into the decoder, predicts every tick
// report from a behavioural copy of the channel state and checks each report
// field by field. A directed opening covers wrap, window edges and sticky
// errors; random traffic then runs under several window settings and idle
// patterns on both handshakes.
// ----------------------------------------------------------------------------
module testbench;

	import rcpwd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int SEGMENTS     = 9;
	localparam int SEG_ITEMS    = 78;
	localparam int OPEN_STEPS   = 24;

	typedef struct packed {
		logic [CMD_W-1:0]      thr;
		logic [CMD_W-1:0]      roll;
		logic [CMD_W-1:0]      pitch;
		logic [CMD_W-1:0]      rud;
		logic [NUM_REPORT-1:0] mask;
		err_code_t             err;
	} report_t;

	typedef struct packed {
		func_t       f;
		logic [1:0]  ch;
		logic [15:0] t;
		logic        typed;
		report_t     rep;
	} step_t;

	localparam report_t BLANK = '{16'd0, 16'd0, 16'd0, 16'd0, 4'd0, ERR_NONE};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 func;
	logic [CHAN_W-1:0]    chan;
	logic [15:0]          capture_time;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CMD_W-1:0]     cmd_throttle;
	logic [CMD_W-1:0]     cmd_roll;
	logic [CMD_W-1:0]     cmd_pitch;
	logic [CMD_W-1:0]     cmd_rudder;
	logic [NUM_REPORT-1:0] present_mask;
	logic [1:0]           error_code;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	logic [15:0] lim_abort_hi, lim_clamp_hi, lim_abort_lo, lim_clamp_lo;
	logic        awaiting_fall [4];
	logic [15:0] rise_at [4];
	logic [15:0] width_us [4];
	logic        fresh [4];
	logic [15:0] cmd_us [4];
	logic [15:0] miss_ticks [4];
	err_code_t   sticky;

	report_t     pending_reports [$];
	report_t     want_rep;
	step_t       opening_steps [OPEN_STEPS];
	int          mismatches = 0;
	int          send_idle_pct = 0;
	int          hold_pct = 0;
	int unsigned cycle_count;

	rc_pulse_width_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.chan         (chan),
		.capture_time (capture_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cmd_throttle (cmd_throttle),
		.cmd_roll     (cmd_roll),
		.cmd_pitch    (cmd_pitch),
		.cmd_rudder   (cmd_rudder),
		.present_mask (present_mask),
		.error_code   (error_code),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit decode_item(input func_t f, input logic [1:0] ch,
			input logic [15:0] t, output report_t rep);
		logic [15:0] w;
		logic [15:0] s;
		rep = BLANK;
		if (f == FUNC_CAPTURE) begin
			if (!awaiting_fall[ch]) begin
				rise_at[ch] = t;
				awaiting_fall[ch] = 1'b1;
				fresh[ch] = 1'b0;
			end else begin
				width_us[ch] = t - rise_at[ch];
				awaiting_fall[ch] = 1'b0;
				fresh[ch] = 1'b1;
			end
			return 1'b0;
		end
		for (int i = 0; i < 4; i++) begin
			if (fresh[i]) begin
				w = width_us[i];
				if (w > lim_abort_hi)
					sticky = ERR_LONG;
				else if (w > lim_clamp_hi)
					w = lim_clamp_hi;
				if (w < lim_abort_lo)
					sticky = ERR_SHORT;
				else if (w < lim_clamp_lo)
					w = lim_clamp_lo;
				width_us[i] = w;
				s = w;
				if (s > lim_clamp_hi)
					s = lim_clamp_hi;
				if (s < lim_clamp_lo)
					s = lim_clamp_lo;
				cmd_us[i] = s - lim_clamp_lo;
				miss_ticks[i] = 16'd0;
			end else if (miss_ticks[i] != 16'hFFFF) begin
				miss_ticks[i] = miss_ticks[i] + 16'd1;
			end
		end
		rep.thr   = cmd_us[0];
		rep.roll  = cmd_us[1];
		rep.pitch = cmd_us[2];
		rep.rud   = cmd_us[3];
		for (int i = 0; i < 4; i++)
			rep.mask[i] = (miss_ticks[i] == 16'd0);
		rep.err = sticky;
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch %s: got %h, want %h", what, got, want);
		mismatches++;
	endtask

	task automatic send_item(input func_t f, input logic [1:0] ch, input logic [15:0] t,
			input logic typed, input report_t typed_rep);
		report_t rep;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		chan         <= ch;
		capture_time <= t;
		do @(posedge clk); while (in_stall);
		if (decode_item(f, ch, t, rep))
			pending_reports.push_back(typed ? typed_rep : rep);
	endtask

	task automatic settle_block;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		// captures give no report: allow the input and output stages to drain
		repeat (4) @(posedge clk);
	endtask

	task automatic program_window(input logic [15:0] ah, input logic [15:0] chh,
			input logic [15:0] al, input logic [15:0] cl);
		logic [15:0] vals [4];
		reg_idx_t    idx;
		vals = '{ah, chh, al, cl};
		settle_block();
		for (int k = 0; k < 4; k++) begin
			idx = reg_idx_t'(k);
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			case (idx)
				REG_ABORT_HIGH: lim_abort_hi = vals[k];
				REG_CLAMP_HIGH: lim_clamp_hi = vals[k];
				REG_ABORT_LOW:  lim_abort_lo = vals[k];
				REG_CLAMP_LOW:  lim_clamp_lo = vals[k];
			endcase
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item;
		int          r;
		func_t       f;
		logic [1:0]  ch;
		logic [15:0] t;
		logic [15:0] w;
		r  = $urandom_range(99);
		ch = 2'($urandom_range(3));
		t  = 16'($urandom);
		f  = FUNC_CAPTURE;
		if (r < 12) begin
			f = func_t'($urandom_range(1));
		end else if (r < 35) begin
			f = FUNC_TICK;
		end else if (awaiting_fall[ch]) begin
			case ($urandom_range(9))
				0: w = 16'($urandom);
				1: w = 16'd0;
				2: w = 16'hFFFF;
				3: w = lim_abort_hi + 16'($urandom_range(6)) - 16'd3;
				4: w = lim_clamp_hi + 16'($urandom_range(6)) - 16'd3;
				5: w = lim_abort_lo + 16'($urandom_range(6)) - 16'd3;
				6: w = lim_clamp_lo + 16'($urandom_range(6)) - 16'd3;
				default: w = 16'($urandom_range(lim_abort_lo, lim_abort_hi));
			endcase
			t = rise_at[ch] + w;
		end
		send_item(f, ch, t, 1'b0, BLANK);
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < hold_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				flag_mismatch("unexpected report", cmd_throttle, 16'd0);
			end else begin
				want_rep = pending_reports.pop_front();
				if (cmd_throttle !== want_rep.thr)
					flag_mismatch("cmd_throttle", cmd_throttle, want_rep.thr);
				if (cmd_roll !== want_rep.roll)
					flag_mismatch("cmd_roll", cmd_roll, want_rep.roll);
				if (cmd_pitch !== want_rep.pitch)
					flag_mismatch("cmd_pitch", cmd_pitch, want_rep.pitch);
				if (cmd_rudder !== want_rep.rud)
					flag_mismatch("cmd_rudder", cmd_rudder, want_rep.rud);
				if (present_mask !== want_rep.mask)
					flag_mismatch("present_mask", 16'(present_mask), 16'(want_rep.mask));
				if (error_code !== want_rep.err)
					flag_mismatch("error_code", 16'(error_code), 16'(want_rep.err));
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [15:0] lo, hi;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		func         <= FUNC_CAPTURE;
		chan         <= 2'd0;
		capture_time <= 16'd0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_ABORT_HIGH;
		cfg_data     <= 16'd0;
		lim_abort_hi = ABORT_HIGH_RST;
		lim_clamp_hi = CLAMP_HIGH_RST;
		lim_abort_lo = ABORT_LOW_RST;
		lim_clamp_lo = CLAMP_LOW_RST;
		for (int i = 0; i < 4; i++) begin
			awaiting_fall[i] = 1'b0;
			rise_at[i]       = 16'd0;
			width_us[i]      = 16'd0;
			fresh[i]         = 1'b0;
			cmd_us[i]        = 16'd0;
			miss_ticks[i]    = 16'd0;
		end
		sticky = ERR_NONE;

		opening_steps = '{
			'{FUNC_TICK,    2'd0, 16'd0,     1'b1,
				'{16'd0, 16'd0, 16'd0, 16'd0, 4'b0000, ERR_NONE}},
			'{FUNC_CAPTURE, 2'd0, 16'd100,   1'b0, BLANK},
			'{FUNC_CAPTURE, 2'd0, 16'd1600,  1'b0, BLANK},
			'{FUNC_TICK,    2'd0, 16'd0,     1'b1,
				'{16'd500, 16'd0, 16'd0, 16'd0, 4'b0001, ERR_NONE}},
			'{FUNC_CAPTURE, 2'd1, 16'd65000, 1'b0, BLANK},
			'{FUNC_CAPTURE, 2'd1, 16'd1000,  1'b0, BLANK},
			'{FUNC_TICK,    2'd0, 16'd0,     1'b0, BLANK},
			'{FUNC_CAPTURE, 2'd2, 16'd0,     1'b0, BLANK},
			'{FUNC_CAPTURE, 2'd2, 16'd65535, 1'b0, BLANK},
			'{FUNC_TICK,    2'd0, 16'd0,     1'b1,
				'{16'd500, 16'd536, 16'd1000, 16'd0, 4'b0111, ERR_LONG}},
			'{FUNC_CAPTURE, 2'd3, 16'd65535, 1'b0, BLANK},
			'{FUNC_CAPTURE, 2'd3, 16'd65535, 1'b0, BLANK},
			'{FUNC_TICK,    2'd0, 16'd0,     1'b1,
				'{16'd500, 16'd536, 16'd1000, 16'd0, 4'b1111, ERR_SHORT}},
			'{FUNC_TICK,    2'd3, 16'hFFFF,  1'b0, BLANK},
			'{FUNC_CAPTURE, 2'd3, 16'd200,   1'b0, BLANK},
			'{FUNC_CAPTURE, 2'd2, 16'd5000,  1'b0, BLANK},
			'{FUNC_TICK,    2'd1, 16'd0,     1'b0, BLANK},
			'{FUNC_CAPTURE, 2'd2, 16'd7000,  1'b0, BLANK},
			'{FUNC_CAPTURE, 2'd3, 16'd1200,  1'b0, BLANK},
			'{FUNC_CAPTURE, 2'd0, 16'd3000,  1'b0, BLANK},
			'{FUNC_CAPTURE, 2'd0, 16'd5100,  1'b0, BLANK},
			'{FUNC_CAPTURE, 2'd1, 16'd10,    1'b0, BLANK},
			'{FUNC_CAPTURE, 2'd1, 16'd810,   1'b0, BLANK},
			'{FUNC_TICK,    2'd2, 16'd0,     1'b0, BLANK}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 14;
		hold_pct      = 86;
		foreach (opening_steps[s])
			send_item(opening_steps[s].f, opening_steps[s].ch, opening_steps[s].t,
				opening_steps[s].typed, opening_steps[s].rep);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 3)
				0: begin
					send_idle_pct = 14;
					hold_pct      = 86;
				end
				1: begin
					send_idle_pct = 86;
					hold_pct      = 14;
				end
				default: begin
					send_idle_pct = 0;
					hold_pct      = 0;
				end
			endcase
			case (seg)
				0: program_window(16'd0, 16'd0, 16'd0, 16'd0);
				1: program_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: program_window(16'd3000, 16'd1200, 16'd500, 16'd1800);
				3, 8: begin
					lo = 16'($urandom_range(3000));
					hi = lo + 16'($urandom_range(500));
					program_window(hi + 16'($urandom_range(2000, 500)),
						hi + 16'($urandom_range(1500, 200)), lo, hi);
				end
				4: program_window(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
				5: program_window(ABORT_HIGH_RST, CLAMP_HIGH_RST, ABORT_LOW_RST, CLAMP_LOW_RST);
				6: program_window(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
				default: program_window(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
			endcase
			repeat (SEG_ITEMS)
				random_item();
		end

		settle_block();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
